@@ rtl/ret_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regex escape tokenizer package
// Shared transaction types, token and error codes, and character helpers.
// ----------------------------------------------------------------------------
package ret_pkg;

   // Number of hex digits that follow a \u escape, and the counter width.
   localparam int unsigned DIGIT_CNT_W = 3;
   localparam logic [DIGIT_CNT_W-1:0] HEX_DIGITS = 3'd4;

   // Token kinds on the result channel.
   localparam logic [2:0] KIND_LITERAL = 3'd0;
   localparam logic [2:0] KIND_ALT     = 3'd1;
   localparam logic [2:0] KIND_WILD    = 3'd2;
   localparam logic [2:0] KIND_LPAREN  = 3'd3;
   localparam logic [2:0] KIND_RPAREN  = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;
   localparam logic [2:0] KIND_END     = 3'd6;

   // Error codes.
   localparam logic [2:0] ERR_NONE           = 3'd0;
   localparam logic [2:0] ERR_INVALID_ESCAPE = 3'd1;
   localparam logic [2:0] ERR_BAD_HEX        = 3'd2;
   localparam logic [2:0] ERR_ESCAPE_AT_END  = 3'd3;
   localparam logic [2:0] ERR_UNICODE_SHORT  = 3'd4;

   // Input commands.
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Pattern bytes with a special meaning.
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_V  = 8'h76;

   // Control codes produced by escape letters.
   localparam logic [15:0] CODE_BEL = 16'h0007;
   localparam logic [15:0] CODE_ESC = 16'h001B;
   localparam logic [15:0] CODE_FF  = 16'h000C;
   localparam logic [15:0] CODE_LF  = 16'h000A;
   localparam logic [15:0] CODE_CR  = 16'h000D;
   localparam logic [15:0] CODE_TAB = 16'h0009;
   localparam logic [15:0] CODE_VT  = 16'h000B;

   // Lexer mode.
   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_ESCAPE  = 2'd1,
      MODE_UNICODE = 2'd2
   } lex_mode_type;

   // Input transaction.
   typedef struct packed {
      logic       cmd;
      logic [7:0] ch;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic [2:0]  error_code;
      logic        any_error;
   } rsp_type;

   // Hex digit value in bits 3:0; bit 4 is set when the byte is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b0, 4'(c - 8'h37)};
      end else begin
         d = 5'h10;
      end
      return d;
   endfunction

endpackage

@@ rtl/regex_escape_tokenizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regex escape tokenizer
// Byte-serial lexer for regular-expression patterns with escape handling.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one pattern byte (cmd = 0) or an end-of-pattern
//   marker (cmd = 1) per transaction. The rsp channel carries at most one
//   token per input transaction: a literal, an operator, an error or the end
//   token. A backslash, the u of \u and all but the last hex digit produce no
//   token. The end token reports a dangling escape or a short \u and returns
//   the lexer to its initial state for the next pattern.
//   An accepted byte is held in the input register and decoded against the lexer
//   mode; its token is registered in the result register, which drives rsp.
//   Throughput: one transaction per cycle while the receiver does not stall,
//   set by the single mode-update step between the input register and the
//   result register. Reset clears the valid bits of both registers and the
//   lexer state. When the receiver stalls, the token holds in the result
//   register while the input register can still take one more byte; an item
//   with no token passes even under a stall.
// ----------------------------------------------------------------------------
module regex_escape_tokenizer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ret_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ret_pkg::rsp_type  rsp_data
);

   // Input register.
   logic             in_valid_ff, in_valid_in;
   ret_pkg::req_type in_data_ff;

   // Lexer state.
   ret_pkg::lex_mode_type                 mode_ff, mode_in, mode_nx;
   logic [ret_pkg::DIGIT_CNT_W-1:0]       digits_ff, digits_in, digits_nx;
   logic [15:0]                           hex_ff, hex_in, hex_nx;
   logic                                  inv_ff, inv_in, inv_nx;
   logic                                  err_ff, err_in, err_nx;

   // Result register.
   logic             out_valid_ff, out_valid_in;
   ret_pkg::rsp_type out_data_ff, out_data_in;

   // Token decode.
   logic             tok_has;
   ret_pkg::rsp_type tok;
   logic [4:0]       digit;
   logic             advance;

   // Decode the held byte against the current mode.
   always_comb begin
      mode_nx   = mode_ff;
      digits_nx = digits_ff;
      hex_nx    = hex_ff;
      inv_nx    = inv_ff;
      err_nx    = err_ff;
      tok_has   = 1'b0;
      tok       = '0;
      digit     = ret_pkg::hex_digit(in_data_ff.ch);
      if (in_data_ff.cmd == ret_pkg::CMD_END) begin
         tok_has  = 1'b1;
         tok.kind = ret_pkg::KIND_END;
         case (mode_ff)
            ret_pkg::MODE_ESCAPE:  tok.error_code = ret_pkg::ERR_ESCAPE_AT_END;
            ret_pkg::MODE_UNICODE: tok.error_code = ret_pkg::ERR_UNICODE_SHORT;
            default:               tok.error_code = ret_pkg::ERR_NONE;
         endcase
         tok.any_error = err_ff | (tok.error_code != ret_pkg::ERR_NONE);
         mode_nx   = ret_pkg::MODE_NORMAL;
         digits_nx = '0;
         hex_nx    = '0;
         inv_nx    = 1'b0;
         err_nx    = 1'b0;
      end else begin
         case (mode_ff)
            ret_pkg::MODE_UNICODE: begin
               inv_nx = inv_ff | digit[4];
               hex_nx = {hex_ff[11:0], digit[3:0]};
               if (digits_ff > ret_pkg::DIGIT_CNT_W'(1)) begin
                  digits_nx = digits_ff - ret_pkg::DIGIT_CNT_W'(1);
               end else begin
                  digits_nx = '0;
                  mode_nx   = ret_pkg::MODE_NORMAL;
                  tok_has   = 1'b1;
                  if (inv_nx) begin
                     err_nx         = 1'b1;
                     tok.kind       = ret_pkg::KIND_ERROR;
                     tok.error_code = ret_pkg::ERR_BAD_HEX;
                  end else begin
                     tok.kind  = ret_pkg::KIND_LITERAL;
                     tok.value = hex_nx;
                  end
               end
            end
            ret_pkg::MODE_ESCAPE: begin
               mode_nx  = ret_pkg::MODE_NORMAL;
               tok_has  = 1'b1;
               tok.kind = ret_pkg::KIND_LITERAL;
               case (in_data_ff.ch)
                  ret_pkg::CH_BAR, ret_pkg::CH_DOT, ret_pkg::CH_LPAREN,
                  ret_pkg::CH_RPAREN, ret_pkg::CH_BSLASH:
                     tok.value = {8'h00, in_data_ff.ch};
                  ret_pkg::CH_LOW_A: tok.value = ret_pkg::CODE_BEL;
                  ret_pkg::CH_LOW_E: tok.value = ret_pkg::CODE_ESC;
                  ret_pkg::CH_LOW_F: tok.value = ret_pkg::CODE_FF;
                  ret_pkg::CH_LOW_N: tok.value = ret_pkg::CODE_LF;
                  ret_pkg::CH_LOW_R: tok.value = ret_pkg::CODE_CR;
                  ret_pkg::CH_LOW_T: tok.value = ret_pkg::CODE_TAB;
                  ret_pkg::CH_LOW_V: tok.value = ret_pkg::CODE_VT;
                  ret_pkg::CH_LOW_U: begin
                     tok_has   = 1'b0;
                     mode_nx   = ret_pkg::MODE_UNICODE;
                     digits_nx = ret_pkg::HEX_DIGITS;
                     hex_nx    = '0;
                     inv_nx    = 1'b0;
                  end
                  default: begin
                     err_nx         = 1'b1;
                     tok.kind       = ret_pkg::KIND_ERROR;
                     tok.error_code = ret_pkg::ERR_INVALID_ESCAPE;
                  end
               endcase
            end
            default: begin
               // Normal mode; the unused mode code lands here as well.
               mode_nx = ret_pkg::MODE_NORMAL;
               tok_has = 1'b1;
               case (in_data_ff.ch)
                  ret_pkg::CH_BAR:    tok.kind = ret_pkg::KIND_ALT;
                  ret_pkg::CH_DOT:    tok.kind = ret_pkg::KIND_WILD;
                  ret_pkg::CH_LPAREN: tok.kind = ret_pkg::KIND_LPAREN;
                  ret_pkg::CH_RPAREN: tok.kind = ret_pkg::KIND_RPAREN;
                  ret_pkg::CH_BSLASH: begin
                     tok_has = 1'b0;
                     mode_nx = ret_pkg::MODE_ESCAPE;
                  end
                  default: begin
                     tok.kind  = ret_pkg::KIND_LITERAL;
                     tok.value = {8'h00, in_data_ff.ch};
                  end
               endcase
            end
         endcase
      end
   end

   // The held item moves on when it has no token or the result register frees up.
   assign advance   = in_valid_ff & (~tok_has | ~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // Next values for the registers.
   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      mode_in      = advance ? mode_nx   : mode_ff;
      digits_in    = advance ? digits_nx : digits_ff;
      hex_in       = advance ? hex_nx    : hex_ff;
      inv_in       = advance ? inv_nx    : inv_ff;
      err_in       = advance ? err_nx    : err_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      if (advance && tok_has) begin
         out_valid_in = 1'b1;
         out_data_in  = tok;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= ret_pkg::MODE_NORMAL;
         digits_ff    <= '0;
         hex_ff       <= '0;
         inv_ff       <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         digits_ff    <= digits_in;
         hex_ff       <= hex_in;
         inv_ff       <= inv_in;
         err_ff       <= err_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ rtl/ret_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regex escape tokenizer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ret_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ret_pkg::rsp_type rsp_data
);

   // A stalled transaction holds its token.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Only the end token carries the pattern error summary.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != ret_pkg::KIND_END |-> !rsp_data.any_error)
      else $error("any_error set on a token other than end");

   // Only error and end tokens carry an error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != ret_pkg::KIND_ERROR
         && rsp_data.kind != ret_pkg::KIND_END
      |-> rsp_data.error_code == ret_pkg::ERR_NONE)
      else $error("error code on a non-error token");

   // An end token with an error code must also set any_error and hold value at 16'h0000.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == ret_pkg::KIND_END
         && rsp_data.error_code != ret_pkg::ERR_NONE
      |-> rsp_data.any_error && rsp_data.value == 16'h0000)
      else $error("end token error summary inconsistent");

endmodule

bind regex_escape_tokenizer_top ret_checker u_ret_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ dv/regex_escape_tokenizer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regex escape tokenizer testbench
// Drives pattern bytes and end markers into the tokenizer and checks every
// token against an independent prediction of the lexer. A short directed
// pattern covers operators, escapes, \u sequences and dangling escapes. It is
// followed by randomized patterns under changing back-pressure, including a
// long receiver stall and a full drain between phases.
// ----------------------------------------------------------------------------
module regex_escape_tokenizer_top_tb;

   localparam int unsigned CLOCK_HALF   = 5;
   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned TAIL_CYCLES  = 10;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned PHASE_ITEMS  = 300;

   // Tracks the lexer state and holds the tokens still owed by the block.
   class token_ledger;
      ret_pkg::lex_mode_type mode;
      logic [2:0]            digits_left;
      logic [15:0]           hex_acc;
      logic                  hex_bad;
      logic                  err_seen;
      ret_pkg::rsp_type      expected_tokens[$];
      int unsigned           mismatches;

      function new();
         clear_pattern();
         mismatches = 0;
      endfunction

      function void clear_pattern();
         mode        = ret_pkg::MODE_NORMAL;
         digits_left = '0;
         hex_acc     = '0;
         hex_bad     = 1'b0;
         err_seen    = 1'b0;
      endfunction

      // Bit 4 flags a byte that is not a hex digit of either case.
      function logic [4:0] nibble_of(logic [7:0] c);
         logic [7:0] folded;
         folded = c | 8'h20;
         if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
         if (folded >= "a" && folded <= "f") return {1'b0, 4'(folded - "a" + 8'd10)};
         return 5'h10;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      // Advances the lexer by one accepted transaction and queues its token.
      function void note_request(ret_pkg::req_type item);
         ret_pkg::rsp_type tok;
         logic [4:0]       nib;
         tok = '0;
         if (item.cmd == ret_pkg::CMD_END) begin
            tok.kind = ret_pkg::KIND_END;
            if (mode == ret_pkg::MODE_ESCAPE) tok.error_code = ret_pkg::ERR_ESCAPE_AT_END;
            else if (mode == ret_pkg::MODE_UNICODE) tok.error_code = ret_pkg::ERR_UNICODE_SHORT;
            tok.any_error = err_seen || (tok.error_code != ret_pkg::ERR_NONE);
            expected_tokens.insert(expected_tokens.size(), tok);
            clear_pattern();
            return;
         end
         case (mode)
            ret_pkg::MODE_UNICODE: begin
               nib = nibble_of(item.ch);
               if (nib[4]) hex_bad = 1'b1;
               hex_acc = {hex_acc[11:0], nib[3:0]};
               if (digits_left > 3'd1) begin
                  digits_left = digits_left - 3'd1;
                  return;
               end
               digits_left = '0;
               mode = ret_pkg::MODE_NORMAL;
               if (hex_bad) begin
                  err_seen = 1'b1;
                  tok.kind = ret_pkg::KIND_ERROR;
                  tok.error_code = ret_pkg::ERR_BAD_HEX;
               end else begin
                  tok.kind = ret_pkg::KIND_LITERAL;
                  tok.value = hex_acc;
               end
            end
            ret_pkg::MODE_ESCAPE: begin
               mode = ret_pkg::MODE_NORMAL;
               tok.kind = ret_pkg::KIND_LITERAL;
               case (item.ch)
                  ret_pkg::CH_BAR, ret_pkg::CH_DOT, ret_pkg::CH_LPAREN,
                  ret_pkg::CH_RPAREN, ret_pkg::CH_BSLASH: tok.value = {8'h00, item.ch};
                  ret_pkg::CH_LOW_A: tok.value = ret_pkg::CODE_BEL;
                  ret_pkg::CH_LOW_E: tok.value = ret_pkg::CODE_ESC;
                  ret_pkg::CH_LOW_F: tok.value = ret_pkg::CODE_FF;
                  ret_pkg::CH_LOW_N: tok.value = ret_pkg::CODE_LF;
                  ret_pkg::CH_LOW_R: tok.value = ret_pkg::CODE_CR;
                  ret_pkg::CH_LOW_T: tok.value = ret_pkg::CODE_TAB;
                  ret_pkg::CH_LOW_V: tok.value = ret_pkg::CODE_VT;
                  ret_pkg::CH_LOW_U: begin
                     mode = ret_pkg::MODE_UNICODE;
                     digits_left = ret_pkg::HEX_DIGITS;
                     hex_acc = '0;
                     hex_bad = 1'b0;
                     return;
                  end
                  default: begin
                     err_seen = 1'b1;
                     tok.kind = ret_pkg::KIND_ERROR;
                     tok.error_code = ret_pkg::ERR_INVALID_ESCAPE;
                  end
               endcase
            end
            default: begin
               mode = ret_pkg::MODE_NORMAL;
               case (item.ch)
                  ret_pkg::CH_BAR:    tok.kind = ret_pkg::KIND_ALT;
                  ret_pkg::CH_DOT:    tok.kind = ret_pkg::KIND_WILD;
                  ret_pkg::CH_LPAREN: tok.kind = ret_pkg::KIND_LPAREN;
                  ret_pkg::CH_RPAREN: tok.kind = ret_pkg::KIND_RPAREN;
                  ret_pkg::CH_BSLASH: begin
                     mode = ret_pkg::MODE_ESCAPE;
                     return;
                  end
                  default: begin
                     tok.kind = ret_pkg::KIND_LITERAL;
                     tok.value = {8'h00, item.ch};
                  end
               endcase
            end
         endcase
         expected_tokens.insert(expected_tokens.size(), tok);
      endfunction

      // Compares one received token with the oldest outstanding one.
      function void check_token(ret_pkg::rsp_type got);
         ret_pkg::rsp_type want;
         if (expected_tokens.size() == 0) begin
            $error("token with nothing pending: kind %0d value 0x%04h", got.kind, got.value);
            mismatches++;
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind != want.kind) begin
            $error("kind mismatch: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
         end
         if (got.value != want.value) begin
            $error("value mismatch: expected 0x%04h, got 0x%04h", want.value, got.value);
            mismatches++;
         end
         if (got.error_code != want.error_code) begin
            $error("error_code mismatch: expected %0d, got %0d", want.error_code,
                   got.error_code);
            mismatches++;
         end
         if (got.any_error != want.any_error) begin
            $error("any_error mismatch: expected %0d, got %0d", want.any_error, got.any_error);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ret_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ret_pkg::rsp_type rsp_data;

   token_ledger      ledger = new();
   ret_pkg::req_type stim_q[$];
   int unsigned      req_gap_pct = 0;
   int unsigned      rsp_stall_pct = 0;
   int unsigned      hold_requests = 0;
   int unsigned      hold_taken = 0;
   int unsigned      hold_left = 0;
   int unsigned      cycle_count = 0;

   regex_escape_tokenizer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver side: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_taken != hold_requests) begin
         hold_taken = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_token(rsp_data);
   end

   function automatic void push_char(logic [7:0] c);
      ret_pkg::req_type item;
      item.cmd = ret_pkg::CMD_CHAR;
      item.ch = c;
      stim_q.insert(stim_q.size(), item);
   endfunction

   // The byte that rides along with an end marker is random; the block ignores it.
   function automatic void push_end();
      ret_pkg::req_type item;
      item.cmd = ret_pkg::CMD_END;
      item.ch = 8'($urandom_range(255));
      stim_q.insert(stim_q.size(), item);
   endfunction

   function automatic logic [7:0] random_hex_char();
      string hex_chars;
      hex_chars = "0123456789abcdefABCDEF";
      return hex_chars[$urandom_range(21)];
   endfunction

   // Adds random pattern fragments until about item_goal items are queued.
   function automatic void build_random(int unsigned item_goal);
      logic [7:0]  escape_chars[12];
      logic [7:0]  op_chars[4];
      int unsigned pick;
      int unsigned n_digits;
      escape_chars = '{ret_pkg::CH_BAR, ret_pkg::CH_DOT, ret_pkg::CH_LPAREN,
                       ret_pkg::CH_RPAREN, ret_pkg::CH_BSLASH, ret_pkg::CH_LOW_A,
                       ret_pkg::CH_LOW_E, ret_pkg::CH_LOW_F, ret_pkg::CH_LOW_N,
                       ret_pkg::CH_LOW_R, ret_pkg::CH_LOW_T, ret_pkg::CH_LOW_V};
      op_chars = '{ret_pkg::CH_BAR, ret_pkg::CH_DOT, ret_pkg::CH_LPAREN,
                   ret_pkg::CH_RPAREN};
      while (stim_q.size() < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            push_char(8'($urandom_range(255)));
         end else if (pick < 50) begin
            push_char(op_chars[$urandom_range(3)]);
         end else if (pick < 70) begin
            // Mostly valid escapes, sometimes an arbitrary escaped byte.
            push_char(ret_pkg::CH_BSLASH);
            if ($urandom_range(99) < 80) push_char(escape_chars[$urandom_range(11)]);
            else push_char(8'($urandom_range(255)));
         end else if (pick < 82) begin
            // A full \u sequence, now and then with a non-hex digit.
            push_char(ret_pkg::CH_BSLASH);
            push_char(ret_pkg::CH_LOW_U);
            for (int i = 0; i < ret_pkg::HEX_DIGITS; i++) begin
               if ($urandom_range(99) < 5) push_char(8'($urandom_range(255)));
               else push_char(random_hex_char());
            end
         end else if (pick < 90) begin
            push_end();
         end else begin
            // Pattern cut off inside an escape or a \u sequence.
            push_char(ret_pkg::CH_BSLASH);
            if ($urandom_range(1) == 1) begin
               push_char(ret_pkg::CH_LOW_U);
               n_digits = $urandom_range(ret_pkg::HEX_DIGITS - 1);
               for (int i = 0; i < n_digits; i++) push_char(random_hex_char());
            end
            push_end();
         end
      end
   endfunction

   // Offers every queued item in order, idling between items at random.
   task automatic drive_queue();
      ret_pkg::req_type item;
      while (stim_q.size() > 0) begin
         item = stim_q.pop_front();
         while ($urandom_range(99) < req_gap_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data <= item;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         ledger.note_request(item);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Returns at a falling edge once every expected token has arrived.
   task automatic wait_drained();
      while (ledger.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pattern: byte extremes, all operators, escapes, \u cases,
      // and end markers after an error, a lone backslash and a short \u.
      push_char(8'h00);
      push_char(8'hFF);
      push_char(ret_pkg::CH_BAR);
      push_char(ret_pkg::CH_DOT);
      push_char(ret_pkg::CH_LPAREN);
      push_char(ret_pkg::CH_RPAREN);
      push_char(ret_pkg::CH_BSLASH);
      push_char(ret_pkg::CH_LOW_A);
      push_char(ret_pkg::CH_BSLASH);
      push_char("x");
      push_char(ret_pkg::CH_BSLASH);
      push_char(ret_pkg::CH_LOW_U);
      push_char("F");
      push_char("f");
      push_char("0");
      push_char("9");
      push_char(ret_pkg::CH_BSLASH);
      push_char(ret_pkg::CH_LOW_U);
      push_char("g");
      push_char("1");
      push_char("2");
      push_char("A");
      push_end();
      push_char(ret_pkg::CH_BSLASH);
      push_end();
      push_char(ret_pkg::CH_BSLASH);
      push_char(ret_pkg::CH_LOW_U);
      push_char("1");
      push_end();
      push_end();

      req_gap_pct = 35;
      rsp_stall_pct = 75;
      drive_queue();
      build_random(PHASE_ITEMS);
      drive_queue();
      wait_drained();

      req_gap_pct = 75;
      rsp_stall_pct = 35;
      build_random(PHASE_ITEMS);
      drive_queue();
      wait_drained();

      // No idling, but a long receiver hold-off so the block backs up.
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      hold_requests = hold_requests + 1;
      build_random(PHASE_ITEMS);
      drive_queue();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
